// ===== src/skt_pkg.sv =====
// Shared types, sizes and codes for the sorted key table.
// No dependencies; every other file in src/ refers to this package by scoped names.
package skt_pkg;

    localparam int CAPACITY = 128;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Reduction tree: cells are gathered in groups, then the groups are combined.
    localparam int GRP      = 16;
    localparam int NGRP     = (CAPACITY + GRP - 1) / GRP;

    localparam int KEY_W    = 64;
    localparam int VAL_W    = 32;
    localparam int OP_W     = 2;
    localparam int ST_W     = 2;
    localparam int POS_W    = 7;
    localparam int ECNT_W   = 8;

    localparam int IN_FIELDS_W  = OP_W + KEY_W + KEY_W + VAL_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = ST_W + POS_W + VAL_W + ECNT_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [ST_W-1:0] ST_DUPLICATE = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic [KEY_W-1:0] key_high;
        logic [KEY_W-1:0] key_low;
        logic [VAL_W-1:0] value;
    } t_entry;

    typedef struct packed {
        logic load;   // take the new entry
        logic up;     // take the entry of the cell below
        logic dn;     // take the entry of the cell above
    } t_cell_ctl;

    typedef struct packed {
        logic             hit;    // first occupied entry not below the key exists
        logic [IDX_W-1:0] idx;    // its index
        logic             found;  // an occupied entry equals the key
        logic [VAL_W-1:0] value;  // handle of that entry
    } t_search;

endpackage

// ===== src/sorted_key_table_top.sv =====
// Top level of the sorted key table: input/output stream registers, control
// sequencer, entry count and the chain of cells. Uses skt_pkg, skt_cell, skt_reduce.
//
//  Channel  Dir  Beat contents (tdata, low bit first)
//  -------  ---  ---------------------------------------------------------------
//  s_axis   in   operation[1:0], key_high[65:2], key_low[129:66], value_in[161:130]
//  m_axis   out  status[1:0], position[8:2], value_out[40:9], entry_count[48:41]
//
// Each entry lives in one cell of a chain of CAPACITY cells kept in ascending
// key order; an insert shifts the cells above the insertion point up by one and
// a delete shifts them down, all together, each cell taking its neighbor.
// An operation goes from the accepting edge to the result register through
// the per-cell key compare, the registered group and final reduction that
// find the lower bound and the matching handle, and the decide-and-shift
// step. s_axis_tready is high only while the sequencer is idle, so a new
// beat is taken only once the previous beat has passed its decide step. A
// finished result waits in the output register; the next beat may enter
// meanwhile, and its decide step holds until the waiting result is taken.
// Reset (i_rst_n low, synchronous) empties the table by clearing the entry
// count; cell contents are not cleared.
module sorted_key_table_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // operation, key_high, key_low, value_in; zero padded
    input  logic [skt_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // status, position, value_out, entry_count; zero padded
    output logic [skt_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CMP  = 3'd1;
    localparam logic [2:0] S_GRP  = 3'd2;
    localparam logic [2:0] S_FIN  = 3'd3;
    localparam logic [2:0] S_EXEC = 3'd4;

    localparam int OP_LO = 0;
    localparam int KH_LO = skt_pkg::OP_W;
    localparam int KL_LO = KH_LO + skt_pkg::KEY_W;
    localparam int VI_LO = KL_LO + skt_pkg::KEY_W;

    logic [2:0]                        r_state, n_state;
    logic [skt_pkg::CNT_W-1:0]         r_count, n_count;
    logic [skt_pkg::OP_W-1:0]          r_op;
    skt_pkg::t_entry                   r_new;
    logic                              r_m_valid, n_m_valid;
    logic [skt_pkg::OUT_TDATA_W-1:0]   r_m_data, n_m_data;

    skt_pkg::t_entry                   cell_entry [skt_pkg::CAPACITY];
    skt_pkg::t_cell_ctl                cell_ctl   [skt_pkg::CAPACITY];
    logic [skt_pkg::VAL_W-1:0]         cell_value [skt_pkg::CAPACITY];
    logic [skt_pkg::CAPACITY-1:0]      cell_below;
    logic [skt_pkg::CAPACITY-1:0]      cell_eq;
    skt_pkg::t_search                  res;

    logic                              in_take;
    logic                              out_free;
    logic                              exec_go;
    logic                              full;
    logic [skt_pkg::IDX_W-1:0]         at;
    logic                              ins_commit;
    logic                              del_commit;
    logic [skt_pkg::ST_W-1:0]          st;
    logic [skt_pkg::POS_W-1:0]         pos;
    logic [skt_pkg::VAL_W-1:0]         vout;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_m_valid || m_axis_tready;
    assign exec_go       = (r_state == S_EXEC) && out_free;
    assign full          = (r_count == skt_pkg::CNT_W'(skt_pkg::CAPACITY));

    // No boundary among occupied cells means the key goes after the last entry.
    assign at = res.hit ? res.idx : r_count[skt_pkg::IDX_W-1:0];

    assign ins_commit = exec_go && (r_op == skt_pkg::OP_INSERT) && !full && !res.found;
    assign del_commit = exec_go && (r_op == skt_pkg::OP_DELETE) && res.found;

    // Chain of cells
    for (genvar i = 0; i < skt_pkg::CAPACITY; i++) begin : g_cell
        skt_pkg::t_entry prev_entry, next_entry;

        if (i == 0) begin : g_first
            assign prev_entry = r_new;
        end else begin : g_mid_lo
            assign prev_entry = cell_entry[i-1];
        end

        if (i == skt_pkg::CAPACITY - 1) begin : g_last
            assign next_entry = cell_entry[i];
        end else begin : g_mid_hi
            assign next_entry = cell_entry[i+1];
        end

        assign cell_ctl[i].load = ins_commit && (skt_pkg::IDX_W'(i) == at);
        assign cell_ctl[i].up   = ins_commit && (skt_pkg::IDX_W'(i) >  at);
        assign cell_ctl[i].dn   = del_commit && (skt_pkg::IDX_W'(i) >= at);
        assign cell_value[i]    = cell_entry[i].value;

        skt_cell u_cell (
            .i_clk   (i_clk),
            .i_new   (r_new),
            .i_prev  (prev_entry),
            .i_next  (next_entry),
            .i_ctl   (cell_ctl[i]),
            .o_entry (cell_entry[i]),
            .o_below (cell_below[i]),
            .o_eq    (cell_eq[i])
        );
    end

    skt_reduce u_reduce (
        .i_clk   (i_clk),
        .i_below (cell_below),
        .i_eq    (cell_eq),
        .i_value (cell_value),
        .i_count (r_count),
        .o_res   (res)
    );

    // Sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    n_state = S_CMP;
                end
            end
            S_CMP:  n_state = S_GRP;
            S_GRP:  n_state = S_FIN;
            S_FIN:  n_state = S_EXEC;
            S_EXEC: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Decide the result and the count update.
    always_comb begin
        st      = skt_pkg::ST_NOT_FOUND;
        pos     = '0;
        vout    = '0;
        n_count = r_count;
        case (r_op)
            skt_pkg::OP_INSERT: begin
                if (full) begin
                    st = skt_pkg::ST_FULL;
                end else if (res.found) begin
                    st  = skt_pkg::ST_DUPLICATE;
                    pos = skt_pkg::POS_W'(at);
                end else begin
                    st      = skt_pkg::ST_OK;
                    pos     = skt_pkg::POS_W'(at);
                    n_count = r_count + 1'b1;
                end
            end
            skt_pkg::OP_DELETE: begin
                if (res.found) begin
                    st      = skt_pkg::ST_OK;
                    pos     = skt_pkg::POS_W'(at);
                    vout    = res.value;
                    n_count = r_count - 1'b1;
                end
            end
            default: begin
                // lookup, and the unused code acts as lookup
                if (res.found) begin
                    st   = skt_pkg::ST_OK;
                    pos  = skt_pkg::POS_W'(at);
                    vout = res.value;
                end
            end
        endcase
    end

    // Output register: load on decide, drop once the beat is taken.
    always_comb begin
        n_m_valid = r_m_valid;
        n_m_data  = r_m_data;
        if (m_axis_tready) begin
            n_m_valid = 1'b0;
        end
        if (exec_go) begin
            n_m_valid = 1'b1;
            n_m_data  = {{(skt_pkg::OUT_TDATA_W - skt_pkg::OUT_FIELDS_W){1'b0}},
                         skt_pkg::ECNT_W'(n_count), vout, pos, st};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
            if (exec_go) begin
                r_count <= n_count;
            end
        end
    end

    // Hold the beat's payload from acceptance until the next acceptance.
    always_ff @(posedge i_clk) begin
        r_m_data <= n_m_data;
        if (in_take) begin
            r_op           <= s_axis_tdata[OP_LO +: skt_pkg::OP_W];
            r_new.key_high <= s_axis_tdata[KH_LO +: skt_pkg::KEY_W];
            r_new.key_low  <= s_axis_tdata[KL_LO +: skt_pkg::KEY_W];
            r_new.value    <= s_axis_tdata[VI_LO +: skt_pkg::VAL_W];
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

endmodule

// ===== src/skt_cell.sv =====
// One storage cell of the sorted key chain: holds an entry, compares it to the
// broadcast key and shifts to or from its neighbors. Uses skt_pkg.
module skt_cell (
    input  logic               i_clk,
    input  skt_pkg::t_entry    i_new,    // broadcast key and value of the current beat
    input  skt_pkg::t_entry    i_prev,   // entry of the cell one index lower
    input  skt_pkg::t_entry    i_next,   // entry of the cell one index higher
    input  skt_pkg::t_cell_ctl i_ctl,
    output skt_pkg::t_entry    o_entry,
    output logic               o_below,  // stored key < broadcast key
    output logic               o_eq      // stored key == broadcast key
);

    skt_pkg::t_entry r_entry, n_entry;
    logic            r_below, r_eq;
    logic            hi_eq;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.load) begin
            n_entry = i_new;
        end else if (i_ctl.up) begin
            n_entry = i_prev;
        end else if (i_ctl.dn) begin
            n_entry = i_next;
        end
    end

    assign hi_eq = (r_entry.key_high == i_new.key_high);

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        r_below <= (r_entry.key_high < i_new.key_high) ||
                   (hi_eq && (r_entry.key_low < i_new.key_low));
        r_eq    <= hi_eq && (r_entry.key_low == i_new.key_low);
    end

    assign o_entry = r_entry;
    assign o_below = r_below;
    assign o_eq    = r_eq;

endmodule

// ===== src/skt_reduce.sv =====
// Two-level registered reduction over the cell flags: finds the lower-bound
// index and the matching entry's handle. Uses skt_pkg.
module skt_reduce (
    input  logic                            i_clk,
    input  logic [skt_pkg::CAPACITY-1:0]    i_below,
    input  logic [skt_pkg::CAPACITY-1:0]    i_eq,
    input  logic [skt_pkg::VAL_W-1:0]       i_value [skt_pkg::CAPACITY],
    input  logic [skt_pkg::CNT_W-1:0]       i_count,
    output skt_pkg::t_search                o_res
);

    logic [skt_pkg::CAPACITY-1:0] occ;
    logic [skt_pkg::CAPACITY-1:0] prev_below;
    skt_pkg::t_search             n_grp [skt_pkg::NGRP];
    skt_pkg::t_search             r_grp [skt_pkg::NGRP];
    skt_pkg::t_search             n_res, r_res;

    // Entry 0 has no lower neighbor; treat it as below so it can be the boundary.
    assign prev_below = {i_below[skt_pkg::CAPACITY-2:0], 1'b1};

    always_comb begin
        for (int i = 0; i < skt_pkg::CAPACITY; i++) begin
            occ[i] = (skt_pkg::CNT_W'(i) < i_count);
        end
    end

    // Stage one: one partial result per group of cells.
    always_comb begin
        int idx;
        for (int g = 0; g < skt_pkg::NGRP; g++) begin
            n_grp[g] = '0;
            for (int k = 0; k < skt_pkg::GRP; k++) begin
                idx = g * skt_pkg::GRP + k;
                if (idx < skt_pkg::CAPACITY) begin
                    if (occ[idx] && !i_below[idx] && prev_below[idx]) begin
                        n_grp[g].hit = 1'b1;
                        n_grp[g].idx = n_grp[g].idx | skt_pkg::IDX_W'(idx);
                    end
                    if (occ[idx] && i_eq[idx]) begin
                        n_grp[g].found = 1'b1;
                        n_grp[g].value = n_grp[g].value | i_value[idx];
                    end
                end
            end
        end
    end

    // Stage two: combine groups. At most one group carries the boundary or a match.
    always_comb begin
        n_res = '0;
        for (int g = 0; g < skt_pkg::NGRP; g++) begin
            n_res.hit   = n_res.hit   | r_grp[g].hit;
            n_res.idx   = n_res.idx   | r_grp[g].idx;
            n_res.found = n_res.found | r_grp[g].found;
            n_res.value = n_res.value | r_grp[g].value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_grp <= n_grp;
        r_res <= n_res;
    end

    assign o_res = r_res;

endmodule
